// ===== sv/elp_pkg.sv =====
// Shared types, constants and helper functions for the ellipse point pipeline.
package elp_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int COORD_BITS = 32;

    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_STEPS = 32;
    localparam int DIST_BITS = 48;
    localparam int DIV_STEPS = DIST_BITS + 30;

    localparam logic [31:0] ANGLE_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);
    localparam int ANGLE_SHIFT = 32 - ANGLE_BITS;

    localparam logic signed [33:0] TRIG_ONE = 34'sd1073741824;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [23:0] UNIT_RADIUS = 24'd256;
    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

    localparam logic signed [51:0] COORD_MAX = (52'sd1 <<< (COORD_BITS - 1)) - 52'sd1;
    localparam logic signed [51:0] COORD_MIN = -(52'sd1 <<< (COORD_BITS - 1));

    localparam logic [2:0] REG_RADIUS_MAJOR = 3'd0;
    localparam logic [2:0] REG_RADIUS_MINOR = 3'd1;
    localparam logic [2:0] REG_TILT_ANGLE = 3'd2;
    localparam logic [2:0] REG_CENTER_X = 3'd3;
    localparam logic [2:0] REG_CENTER_Y = 3'd4;

    localparam logic [31:0] ATAN_TURNS [0:29] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1
    };

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [32:0] z;
        logic [1:0]         quad;
        logic               zero;
    } elp_rot_t;

    typedef struct packed {
        elp_rot_t ray;
        elp_rot_t phi;
    } elp_rot_pair_t;

    typedef struct packed {
        logic signed [31:0] c;
        logic signed [31:0] s;
    } elp_trig_t;

    typedef struct packed {
        logic signed [31:0] cp;
        logic signed [31:0] sp;
        logic [4:0]         e;
        logic               center;
    } elp_side_t;

    typedef struct packed {
        logic [63:0] n;
        logic [63:0] res;
    } elp_sqrt_t;

    typedef struct packed {
        logic [31:0]           rem;
        logic [31:0]           len;
        logic [DIV_STEPS-1:0]  dvd;
        logic [DIST_BITS-1:0]  q;
        logic                  ovf;
    } elp_div_t;

    typedef struct packed {
        logic        clip;
        logic [31:0] value;
    } elp_sat_t;

    // Folds the angle into the quadrant around zero and seeds the rotation.
    function automatic elp_rot_t trig_init(input logic [31:0] a);
        elp_rot_t    r;
        logic [31:0] sum;
        logic [31:0] res;
        sum = a + 32'h2000_0000;
        r.quad = sum[31:30];
        res = a - {r.quad, 30'b0};
        r.zero = (res == 32'd0);
        r.x = r.zero ? TRIG_ONE : CORDIC_GAIN;
        r.y = 34'sd0;
        r.z = {res[31], res};
        return r;
    endfunction

    function automatic logic signed [31:0] clamp_one(input logic signed [33:0] v);
        logic signed [31:0] o;
        if (v > TRIG_ONE)
        begin
            o = 32'(TRIG_ONE);
        end
        else if (v < -TRIG_ONE)
        begin
            o = -32'(TRIG_ONE);
        end
        else
        begin
            o = 32'(v);
        end
        return o;
    endfunction

    function automatic elp_trig_t trig_map(input elp_rot_t r);
        elp_trig_t          t;
        logic signed [31:0] x;
        logic signed [31:0] y;
        x = clamp_one(r.x);
        y = clamp_one(r.y);
        case (r.quad)
            2'd0:
            begin
                t.c = x;
                t.s = y;
            end
            2'd1:
            begin
                t.c = -y;
                t.s = x;
            end
            2'd2:
            begin
                t.c = -x;
                t.s = -y;
            end
            default:
            begin
                t.c = y;
                t.s = -x;
            end
        endcase
        return t;
    endfunction

    function automatic elp_sat_t sat_coord(input logic signed [51:0] v);
        elp_sat_t o;
        o.clip = 1'b1;
        if (v > COORD_MAX)
        begin
            o.value = COORD_MAX[31:0];
        end
        else if (v < COORD_MIN)
        begin
            o.value = COORD_MIN[31:0];
        end
        else
        begin
            o.clip = 1'b0;
            o.value = v[31:0];
        end
        return o;
    endfunction

endpackage

// ===== sv/elp_if.sv =====
// Stream interfaces for the angle input and the point output.
interface elp_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] ray_angle;
    logic        apply_tilt;

    modport source (output valid, output ray_angle, output apply_tilt, input ready);
    modport sink (input valid, input ray_angle, input apply_tilt, output ready);
endinterface

interface elp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               at_center;
    logic               clipped;

    modport source (output valid, output point_x, output point_y, output at_center,
                    output clipped, input ready);
    modport sink (input valid, input point_x, input point_y, input at_center,
                  input clipped, output ready);
endinterface

// ===== sv/elp_cordic_cell.sv =====
// One CORDIC micro-rotation for the ray lane and the tilted lane.
module elp_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  elp_pkg::elp_rot_pair_t in_data,
    output logic                   out_valid,
    output elp_pkg::elp_rot_pair_t out_data
);

    logic                   valid_reg;
    elp_pkg::elp_rot_pair_t data_reg;
    elp_pkg::elp_rot_pair_t data_next;

    function automatic elp_pkg::elp_rot_t rot_step(input elp_pkg::elp_rot_t r);
        elp_pkg::elp_rot_t  o;
        logic signed [33:0] xs;
        logic signed [33:0] ys;
        logic signed [32:0] at;
        o = r;
        xs = r.x >>> STEP;
        ys = r.y >>> STEP;
        at = $signed({1'b0, elp_pkg::ATAN_TURNS[STEP]});
        if (!r.zero)
        begin
            if (!r.z[32])
            begin
                o.x = r.x - ys;
                o.y = r.y + xs;
                o.z = r.z - at;
            end
            else
            begin
                o.x = r.x + ys;
                o.y = r.y - xs;
                o.z = r.z + at;
            end
        end
        return o;
    endfunction

    always_comb
    begin
        data_next.ray = rot_step(in_data.ray);
        data_next.phi = rot_step(in_data.phi);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;

endmodule

// ===== sv/elp_sqrt_cell.sv =====
// One digit of the integer square root, carrying the downstream sideband.
module elp_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  elp_pkg::elp_sqrt_t in_data,
    input  elp_pkg::elp_side_t in_side,
    output logic               out_valid,
    output elp_pkg::elp_sqrt_t out_data,
    output elp_pkg::elp_side_t out_side
);

    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

    logic               valid_reg;
    elp_pkg::elp_sqrt_t data_reg;
    elp_pkg::elp_sqrt_t data_next;
    elp_pkg::elp_side_t side_reg;
    logic [63:0]        trial;

    always_comb
    begin
        trial = in_data.res + BIT;
        if (in_data.n >= trial)
        begin
            data_next.n = in_data.n - trial;
            data_next.res = (in_data.res >> 1) + BIT;
        end
        else
        begin
            data_next.n = in_data.n;
            data_next.res = in_data.res >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;
    assign out_side = side_reg;

endmodule

// ===== sv/elp_div_cell.sv =====
// One quotient bit of the restoring division for the ray distance.
module elp_div_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  elp_pkg::elp_div_t  in_data,
    input  elp_pkg::elp_side_t in_side,
    output logic               out_valid,
    output elp_pkg::elp_div_t  out_data,
    output elp_pkg::elp_side_t out_side
);

    logic               valid_reg;
    elp_pkg::elp_div_t  data_reg;
    elp_pkg::elp_div_t  data_next;
    elp_pkg::elp_side_t side_reg;
    logic [32:0]        part;
    logic [32:0]        diff;
    logic               ge;

    always_comb
    begin
        part = {in_data.rem, in_data.dvd[elp_pkg::DIV_STEPS-1]};
        diff = part - {1'b0, in_data.len};
        ge = (part >= {1'b0, in_data.len});
        data_next.len = in_data.len;
        data_next.rem = ge ? diff[31:0] : part[31:0];
        data_next.dvd = in_data.dvd << 1;
        data_next.q = {in_data.q[elp_pkg::DIST_BITS-2:0], ge};
        // Any quotient bit pushed past the top means the distance overflowed.
        data_next.ovf = in_data.ovf | in_data.q[elp_pkg::DIST_BITS-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;
    assign out_side = side_reg;

endmodule

// ===== sv/ellipse_point_at_angle.sv =====
// Top level: configuration registers and the pipeline that maps a ray angle to an ellipse point.
// Throughput is one transaction per cycle; the whole pipeline advances together and
// holds only while a finished point waits for the output to take it.
// The 150 register stages are 30 CORDIC cells, 32 square-root cells, 78 divider cells and ten more.
// Reset clears all valid bits and the configuration registers to zero.
module ellipse_point_at_angle (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    elp_in_if.sink            in_ch,
    elp_out_if.source         out_ch
);

    localparam int NC = elp_pkg::CORDIC_STEPS;
    localparam int NS = elp_pkg::SQRT_STEPS;
    localparam int ND = elp_pkg::DIV_STEPS;

    // Configuration registers.
    logic [23:0]        rmaj_reg;
    logic [23:0]        rmin_reg;
    logic [15:0]        tilt_reg;
    logic signed [31:0] cx_reg;
    logic signed [31:0] cy_reg;
    logic               wr_en;
    logic [2:0]         reg_idx;

    assign pready = 1'b1;
    assign wr_en = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rmaj_reg <= '0;
            rmin_reg <= '0;
            tilt_reg <= '0;
            cx_reg <= '0;
            cy_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                elp_pkg::REG_RADIUS_MAJOR: rmaj_reg <= pwdata[23:0];
                elp_pkg::REG_RADIUS_MINOR: rmin_reg <= pwdata[23:0];
                elp_pkg::REG_TILT_ANGLE:   tilt_reg <= pwdata[15:0];
                elp_pkg::REG_CENTER_X:     cx_reg <= pwdata;
                elp_pkg::REG_CENTER_Y:     cy_reg <= pwdata;
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            elp_pkg::REG_RADIUS_MAJOR: prdata = {8'b0, rmaj_reg};
            elp_pkg::REG_RADIUS_MINOR: prdata = {8'b0, rmin_reg};
            elp_pkg::REG_TILT_ANGLE:   prdata = {16'b0, tilt_reg};
            elp_pkg::REG_CENTER_X:     prdata = cx_reg;
            elp_pkg::REG_CENTER_Y:     prdata = cy_reg;
            default:                   prdata = 32'd0;
        endcase
    end

    // Effective radii: a zero radius stands in as one unit.
    logic [23:0] r1;
    logic [23:0] r2;
    assign r1 = (rmaj_reg != 24'd0) ? rmaj_reg : elp_pkg::UNIT_RADIUS;
    assign r2 = (rmin_reg != 24'd0) ? rmin_reg : elp_pkg::UNIT_RADIUS;

    logic out_valid_reg;
    logic adv;
    assign adv = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = adv;

    // Front stage: angles in 1/2^32 turn, folded and seeded.
    logic                   f_valid_reg;
    elp_pkg::elp_rot_pair_t f_pair_reg;
    logic [31:0]            a32;
    logic [31:0]            t32;
    logic [31:0]            phi32;

    assign a32 = (32'(in_ch.ray_angle) & elp_pkg::ANGLE_MASK) << elp_pkg::ANGLE_SHIFT;
    assign t32 = (32'(tilt_reg) & elp_pkg::ANGLE_MASK) << elp_pkg::ANGLE_SHIFT;
    assign phi32 = in_ch.apply_tilt ? a32 + t32 : a32;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_pair_reg.ray <= elp_pkg::trig_init(a32);
            f_pair_reg.phi <= elp_pkg::trig_init(phi32);
        end
    end

    // CORDIC row.
    logic                   c_valid [0:NC];
    elp_pkg::elp_rot_pair_t c_pair [0:NC];
    assign c_valid[0] = f_valid_reg;
    assign c_pair[0] = f_pair_reg;

    for (genvar i = 0; i < NC; i++)
    begin : g_cordic
        elp_cordic_cell #(.STEP(i)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (c_valid[i]),
            .in_data   (c_pair[i]),
            .out_valid (c_valid[i+1]),
            .out_data  (c_pair[i+1])
        );
    end

    // Trig stage: clamp and quadrant mapping.
    logic               t_valid_reg;
    elp_pkg::elp_trig_t t_ray_reg;
    elp_pkg::elp_trig_t t_phi_reg;

    // Product stage: u and v terms.
    logic               m_valid_reg;
    logic [54:0]        m_u_reg;
    logic [54:0]        m_v_reg;
    elp_pkg::elp_trig_t m_phi_reg;
    logic [30:0]        abs_c;
    logic [30:0]        abs_s;

    assign abs_c = t_ray_reg.c[31] ? 31'(-t_ray_reg.c) : t_ray_reg.c[30:0];
    assign abs_s = t_ray_reg.s[31] ? 31'(-t_ray_reg.s) : t_ray_reg.s[30:0];

    // Normalize stage: shift u and v under 2^31.
    logic               n_valid_reg;
    logic [30:0]        n_u_reg;
    logic [30:0]        n_v_reg;
    logic [4:0]         n_sh_reg;
    logic               n_center_reg;
    elp_pkg::elp_trig_t n_phi_reg;
    logic [54:0]        nu;
    logic [54:0]        nv;
    logic [4:0]         nsh;

    always_comb
    begin
        nu = m_u_reg;
        nv = m_v_reg;
        nsh = 5'd0;
        for (int k = 4; k >= 0; k--)
        begin
            if (((nu | nv) >> (30 + (1 << k))) != 55'd0)
            begin
                nu = nu >> (1 << k);
                nv = nv >> (1 << k);
                nsh = nsh + 5'(1 << k);
            end
        end
    end

    // Square stage: sum of squares and the fraction bit count.
    logic               s_valid_reg;
    elp_pkg::elp_sqrt_t s_sqrt_reg;
    elp_pkg::elp_side_t s_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            n_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            t_valid_reg <= c_valid[NC];
            m_valid_reg <= t_valid_reg;
            n_valid_reg <= m_valid_reg;
            s_valid_reg <= n_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_ray_reg <= elp_pkg::trig_map(c_pair[NC].ray);
            t_phi_reg <= elp_pkg::trig_map(c_pair[NC].phi);

            m_u_reg <= (rmaj_reg != 24'd0) ? 55'(abs_c) * 55'(r2) : 55'd0;
            m_v_reg <= (rmin_reg != 24'd0) ? 55'(abs_s) * 55'(r1) : 55'd0;
            m_phi_reg <= t_phi_reg;

            n_u_reg <= nu[30:0];
            n_v_reg <= nv[30:0];
            n_sh_reg <= nsh;
            n_center_reg <= (m_u_reg == 55'd0) && (m_v_reg == 55'd0);
            n_phi_reg <= m_phi_reg;

            s_sqrt_reg.n <= 64'(n_u_reg) * 64'(n_u_reg) + 64'(n_v_reg) * 64'(n_v_reg);
            s_sqrt_reg.res <= 64'd0;
            s_side_reg.cp <= n_phi_reg.c;
            s_side_reg.sp <= n_phi_reg.s;
            s_side_reg.e <= 5'd30 - n_sh_reg;
            s_side_reg.center <= n_center_reg;
        end
    end

    // Square-root row.
    logic               q_valid [0:NS];
    elp_pkg::elp_sqrt_t q_data [0:NS];
    elp_pkg::elp_side_t q_side [0:NS];
    assign q_valid[0] = s_valid_reg;
    assign q_data[0] = s_sqrt_reg;
    assign q_side[0] = s_side_reg;

    for (genvar i = 0; i < NS; i++)
    begin : g_sqrt
        elp_sqrt_cell #(.STEP(i)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (q_valid[i]),
            .in_data   (q_data[i]),
            .in_side   (q_side[i]),
            .out_valid (q_valid[i+1]),
            .out_data  (q_data[i+1]),
            .out_side  (q_side[i+1])
        );
    end

    // Divisor and numerator stage, then dividend alignment stage.
    logic                         p_valid_reg;
    logic [31:0]                  p_len_reg;
    logic [elp_pkg::DIST_BITS-1:0] p_num_reg;
    elp_pkg::elp_side_t           p_side_reg;
    logic                         d_valid_reg;
    elp_pkg::elp_div_t            d_div_reg;
    elp_pkg::elp_side_t           d_side_reg;
    logic [31:0]                  root;

    assign root = q_data[NS].res[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p_valid_reg <= q_valid[NS];
            d_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_len_reg <= (root == 32'd0) ? 32'd1 : root;
            p_num_reg <= 48'(r1) * 48'(r2);
            p_side_reg <= q_side[NS];

            d_div_reg.rem <= 32'd0;
            d_div_reg.len <= p_len_reg;
            d_div_reg.dvd <= ND'(p_num_reg) << p_side_reg.e;
            d_div_reg.q <= '0;
            d_div_reg.ovf <= 1'b0;
            d_side_reg <= p_side_reg;
        end
    end

    // Divider row.
    logic               v_valid [0:ND];
    elp_pkg::elp_div_t  v_data [0:ND];
    elp_pkg::elp_side_t v_side [0:ND];
    assign v_valid[0] = d_valid_reg;
    assign v_data[0] = d_div_reg;
    assign v_side[0] = d_side_reg;

    for (genvar i = 0; i < ND; i++)
    begin : g_div
        elp_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (v_valid[i]),
            .in_data   (v_data[i]),
            .in_side   (v_side[i]),
            .out_valid (v_valid[i+1]),
            .out_data  (v_data[i+1]),
            .out_side  (v_side[i+1])
        );
    end

    // Scaling: partial products, rounding, then centre offset and saturation.
    logic [elp_pkg::DIST_BITS-1:0] dist_sat;
    logic [30:0]                   abs_cp;
    logic [30:0]                   abs_sp;
    elp_pkg::elp_side_t            vs;

    assign vs = v_side[ND];
    assign dist_sat = v_data[ND].ovf ? elp_pkg::DIST_MAX : v_data[ND].q;
    assign abs_cp = vs.cp[31] ? 31'(-vs.cp) : vs.cp[30:0];
    assign abs_sp = vs.sp[31] ? 31'(-vs.sp) : vs.sp[30:0];

    logic        x1_valid_reg;
    logic [54:0] x1_hx_reg;
    logic [54:0] x1_lx_reg;
    logic [54:0] x1_hy_reg;
    logic [54:0] x1_ly_reg;
    logic        x1_negx_reg;
    logic        x1_negy_reg;
    logic        x1_center_reg;
    logic        x1_dclip_reg;

    logic        x2_valid_reg;
    logic [49:0] x2_magx_reg;
    logic [49:0] x2_magy_reg;
    logic        x2_negx_reg;
    logic        x2_negy_reg;
    logic        x2_center_reg;
    logic        x2_dclip_reg;

    logic [55:0] lowx;
    logic [55:0] lowy;

    assign lowx = 56'({x1_hx_reg[5:0], 24'b0}) + 56'(x1_lx_reg) + (56'd1 << 29);
    assign lowy = 56'({x1_hy_reg[5:0], 24'b0}) + 56'(x1_ly_reg) + (56'd1 << 29);

    logic signed [51:0] ext_cx;
    logic signed [51:0] ext_cy;
    logic signed [51:0] sum_x;
    logic signed [51:0] sum_y;
    elp_pkg::elp_sat_t  sat_x;
    elp_pkg::elp_sat_t  sat_y;

    assign ext_cx = 52'(cx_reg);
    assign ext_cy = 52'(cy_reg);

    always_comb
    begin
        if (x2_center_reg)
        begin
            sum_x = ext_cx;
            sum_y = ext_cy;
        end
        else
        begin
            // Screen y points down, so the sine offset is subtracted.
            sum_x = x2_negx_reg ? ext_cx - $signed({2'b0, x2_magx_reg})
                                : ext_cx + $signed({2'b0, x2_magx_reg});
            sum_y = x2_negy_reg ? ext_cy + $signed({2'b0, x2_magy_reg})
                                : ext_cy - $signed({2'b0, x2_magy_reg});
        end
        sat_x = elp_pkg::sat_coord(sum_x);
        sat_y = elp_pkg::sat_coord(sum_y);
    end

    logic [31:0] out_x_reg;
    logic [31:0] out_y_reg;
    logic        out_center_reg;
    logic        out_clip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_valid_reg <= 1'b0;
            x2_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            x1_valid_reg <= v_valid[ND];
            x2_valid_reg <= x1_valid_reg;
            out_valid_reg <= x2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_hx_reg <= 55'(dist_sat[47:24]) * 55'(abs_cp);
            x1_lx_reg <= 55'(dist_sat[23:0]) * 55'(abs_cp);
            x1_hy_reg <= 55'(dist_sat[47:24]) * 55'(abs_sp);
            x1_ly_reg <= 55'(dist_sat[23:0]) * 55'(abs_sp);
            x1_negx_reg <= vs.cp[31];
            x1_negy_reg <= vs.sp[31];
            x1_center_reg <= vs.center;
            x1_dclip_reg <= v_data[ND].ovf;

            x2_magx_reg <= 50'(x1_hx_reg >> 6) + 50'(lowx >> 30);
            x2_magy_reg <= 50'(x1_hy_reg >> 6) + 50'(lowy >> 30);
            x2_negx_reg <= x1_negx_reg;
            x2_negy_reg <= x1_negy_reg;
            x2_center_reg <= x1_center_reg;
            x2_dclip_reg <= x1_dclip_reg;

            out_x_reg <= sat_x.value;
            out_y_reg <= sat_y.value;
            out_center_reg <= x2_center_reg;
            out_clip_reg <= (x2_dclip_reg & ~x2_center_reg) | sat_x.clip | sat_y.clip;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.point_x = out_x_reg;
    assign out_ch.point_y = out_y_reg;
    assign out_ch.at_center = out_center_reg;
    assign out_ch.clipped = out_clip_reg;

    // With both radii zero every point is the centre.
    a_zero_radii_center: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rmaj_reg == 24'd0 && rmin_reg == 24'd0) |-> out_center_reg)
        else $error("zero radii did not return the centre");

    // A centre result that did not saturate carries the centre coordinates.
    a_center_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_center_reg && !out_clip_reg)
            |-> (out_x_reg == cx_reg[31:0] && out_y_reg == cy_reg[31:0]))
        else $error("centre result differs from the configured centre");

    // A transaction in the last scaling stage lands in the output register.
    a_last_stage_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && x2_valid_reg) |=> out_valid_reg)
        else $error("transaction lost between scaling and output");

    // A stalled output freezes the front of the pipeline as well.
    a_stall_holds_front: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |=> $stable(f_valid_reg))
        else $error("pipeline moved during an output stall");

endmodule

// ===== bench/ellipse_point_at_angle_checker.sv =====
// Checker for the ellipse point block: tracks the registers, predicts each point and compares.
module ellipse_point_at_angle_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    elp_in_if           in_ch,
    elp_out_if          out_ch,
    output int          fail_count,
    output int          pending,
    output int          points_checked,
    output int          center_seen,
    output int          clip_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        bit                 ctr;
        bit                 clp;
    } point_t;

    point_t points_due[$];

    // Local copy of the configuration, updated from the register bus.
    logic [23:0]        major_r;
    logic [23:0]        minor_r;
    logic [15:0]        tilt_r;
    logic signed [31:0] cx_r;
    logic signed [31:0] cy_r;

    function automatic longint clamp_unit(input longint v);
        if (v > 64'sd1073741824)
        begin
            return 64'sd1073741824;
        end
        if (v < -64'sd1073741824)
        begin
            return -64'sd1073741824;
        end
        return v;
    endfunction

    // Quadrant-folded CORDIC; cos and sin in signed Q2.30.
    function automatic void sin_cos(input logic [31:0] a, output longint co, output longint si);
        logic [31:0] sum;
        logic [1:0]  quad;
        logic [31:0] rest;
        longint      x;
        longint      y;
        longint      z;
        longint      t;
        sum = a + 32'h2000_0000;
        quad = sum[31:30];
        rest = a - {quad, 30'b0};
        z = longint'($signed(rest));
        y = 0;
        if (rest == 32'd0)
        begin
            x = 64'sd1073741824;
        end
        else
        begin
            x = 64'sd652032874;
            for (int i = 0; i < 30; i++)
            begin
                if (z >= 0)
                begin
                    t = x - (y >>> i);
                    y = y + (x >>> i);
                    z = z - longint'(elp_pkg::ATAN_TURNS[i]);
                end
                else
                begin
                    t = x + (y >>> i);
                    y = y - (x >>> i);
                    z = z + longint'(elp_pkg::ATAN_TURNS[i]);
                end
                x = t;
            end
        end
        x = clamp_unit(x);
        y = clamp_unit(y);
        case (quad)
            2'd0:
            begin
                co = x;
                si = y;
            end
            2'd1:
            begin
                co = -y;
                si = x;
            end
            2'd2:
            begin
                co = -x;
                si = -y;
            end
            default:
            begin
                co = y;
                si = -x;
            end
        endcase
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'd1 << 62;
        while (b > n)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (n >= root + b)
            begin
                n = n - (root + b);
                root = (root >> 1) + b;
            end
            else
            begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    // Signed product of a Q.8 distance and a Q2.30 factor, rounded half away from zero.
    function automatic longint offset_of(input longint unsigned d, input longint m);
        longint unsigned mag;
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned r;
        mag = (m < 0) ? longint'(-m) : longint'(m);
        hi = (d >> 24) * mag;
        lo = ((hi & 64'd63) << 24) + (d & 64'hFFFFFF) * mag + (64'd1 << 29);
        r = (hi >> 6) + (lo >> 30);
        return (m < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint saturate(input longint v, inout bit clp);
        if (v > 64'sd2147483647)
        begin
            clp = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            clp = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic point_t ellipse_point(input logic [15:0] ang, input bit tilt);
        point_t          p;
        longint          px;
        longint          py;
        longint          c;
        longint          s;
        longint          cp;
        longint          sp;
        longint unsigned r1;
        longint unsigned r2;
        longint unsigned u;
        longint unsigned v;
        longint unsigned len;
        longint unsigned q;
        longint unsigned rem;
        logic [31:0]     a32;
        logic [31:0]     phi;
        int              sh;
        p.ctr = 1'b0;
        p.clp = 1'b0;
        px = longint'(cx_r);
        py = longint'(cy_r);
        if (major_r != 0 || minor_r != 0)
        begin
            a32 = {ang, 16'b0};
            r1 = (major_r != 0) ? longint'(major_r) : 64'd256;
            r2 = (minor_r != 0) ? longint'(minor_r) : 64'd256;
            sin_cos(a32, c, s);
            u = (major_r != 0) ? longint'((c < 0) ? -c : c) * r2 : 64'd0;
            v = (minor_r != 0) ? longint'((s < 0) ? -s : s) * r1 : 64'd0;
            if (u == 0 && v == 0)
            begin
                p.ctr = 1'b1;
            end
            else
            begin
                sh = 0;
                while (((u | v) >> 31) != 0)
                begin
                    u = u >> 1;
                    v = v >> 1;
                    sh++;
                end
                len = int_sqrt(u * u + v * v);
                if (len == 0)
                begin
                    len = 1;
                end
                q = (r1 * r2) / len;
                rem = (r1 * r2) % len;
                if (q > 64'hFFFF_FFFF_FFFF)
                begin
                    q = 64'hFFFF_FFFF_FFFF;
                    p.clp = 1'b1;
                end
                else
                begin
                    for (int i = 0; i < 30 - sh; i++)
                    begin
                        rem = rem << 1;
                        q = q << 1;
                        if (rem >= len)
                        begin
                            rem = rem - len;
                            q = q | 64'd1;
                        end
                        if (q > 64'hFFFF_FFFF_FFFF)
                        begin
                            q = 64'hFFFF_FFFF_FFFF;
                            p.clp = 1'b1;
                            break;
                        end
                    end
                end
                phi = tilt ? a32 + {tilt_r, 16'b0} : a32;
                sin_cos(phi, cp, sp);
                px = px + offset_of(q, cp);
                py = py - offset_of(q, sp);
            end
        end
        else
        begin
            p.ctr = 1'b1;
        end
        px = saturate(px, p.clp);
        py = saturate(py, p.clp);
        p.x = px[31:0];
        p.y = py[31:0];
        return p;
    endfunction

    assign pending = points_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            major_r <= '0;
            minor_r <= '0;
            tilt_r <= '0;
            cx_r <= '0;
            cy_r <= '0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[4:2])
                elp_pkg::REG_RADIUS_MAJOR: major_r <= pwdata[23:0];
                elp_pkg::REG_RADIUS_MINOR: minor_r <= pwdata[23:0];
                elp_pkg::REG_TILT_ANGLE:   tilt_r <= pwdata[15:0];
                elp_pkg::REG_CENTER_X:     cx_r <= pwdata;
                elp_pkg::REG_CENTER_Y:     cy_r <= pwdata;
                default:                   ;
            endcase
        end
    end

    initial
    begin
        fail_count = 0;
        points_checked = 0;
        center_seen = 0;
        clip_seen = 0;
    end

    always @(posedge clk)
    begin
        point_t want;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            points_due.push_back(ellipse_point(in_ch.ray_angle, in_ch.apply_tilt));
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (points_due.size() == 0)
            begin
                $error("point transaction with nothing expected");
                fail_count++;
            end
            else
            begin
                want = points_due.pop_front();
                points_checked++;
                if (want.ctr)
                begin
                    center_seen++;
                end
                if (want.clp)
                begin
                    clip_seen++;
                end
                if (out_ch.point_x !== want.x)
                begin
                    $error("point_x expected %0d got %0d", want.x, out_ch.point_x);
                    fail_count++;
                end
                if (out_ch.point_y !== want.y)
                begin
                    $error("point_y expected %0d got %0d", want.y, out_ch.point_y);
                    fail_count++;
                end
                if (out_ch.at_center !== want.ctr)
                begin
                    $error("at_center expected %0d got %0d", want.ctr, out_ch.at_center);
                    fail_count++;
                end
                if (out_ch.clipped !== want.clp)
                begin
                    $error("clipped expected %0d got %0d", want.clp, out_ch.clipped);
                    fail_count++;
                end
            end
        end
    end

endmodule

// ===== bench/ellipse_point_at_angle_tb.sv =====
// Testbench top: clock, reset, register writes, angle stimulus, output stalls and verdict.
module ellipse_point_at_angle_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          points_checked;
    int          center_seen;
    int          clip_seen;
    bit          hold_req;
    int          setups;

    elp_in_if  in_ch ();
    elp_out_if out_ch ();

    ellipse_point_at_angle u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    ellipse_point_at_angle_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .in_ch          (in_ch),
        .out_ch         (out_ch),
        .fail_count     (fail_count),
        .pending        (pending),
        .points_checked (points_checked),
        .center_seen    (center_seen),
        .clip_seen      (clip_seen)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Output side: stall modes change every so often; a hold request forces a long stall.
    initial
    begin
        int mode;
        int left;
        out_ch.ready = 1'b0;
        mode = 0;
        left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_req = 1'b0;
            end
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 120);
            end
            left--;
            case (mode)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= ($urandom_range(0, 1) == 0);
                2:       out_ch.ready <= ($urandom_range(0, 9) != 0);
                default: out_ch.ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // Setup and access cycles; the bus is left selected so writes can follow back to back.
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
    endtask

    task automatic set_ellipse(input logic [23:0] rmaj, input logic [23:0] rmin,
                               input logic [15:0] tilt, input logic [31:0] cx,
                               input logic [31:0] cy);
        reg_write(elp_pkg::REG_RADIUS_MAJOR, {8'h0, rmaj});
        reg_write(elp_pkg::REG_RADIUS_MINOR, {8'h0, rmin});
        reg_write(elp_pkg::REG_TILT_ANGLE, {16'h0, tilt});
        reg_write(elp_pkg::REG_CENTER_X, cx);
        reg_write(elp_pkg::REG_CENTER_Y, cy);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        setups++;
    endtask

    // Called at a rising edge; returns at the edge where the angle transaction is taken.
    task automatic send_angle(input logic [15:0] ang, input bit tilt);
        in_ch.valid <= 1'b1;
        in_ch.ray_angle <= ang;
        in_ch.apply_tilt <= tilt;
        forever
        begin
            @(negedge clk);
            if (in_ch.ready)
            begin
                break;
            end
        end
        @(posedge clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (160) @(posedge clk);
    endtask

    function automatic logic [23:0] pick_radius();
        case ($urandom_range(0, 7))
            0:       return 24'd0;
            1:       return 24'hFFFFFF;
            2:       return 24'($urandom_range(1, 4));
            3, 4:    return 24'($urandom_range(256, 256 * 400));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_center();
        case ($urandom_range(0, 5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_angle();
        if ($urandom_range(0, 4) == 0)
        begin
            return {$urandom_range(0, 3), 14'b0} + 16'($urandom_range(0, 2)) - 16'd1;
        end
        return 16'($urandom);
    endfunction

    task automatic random_phase(input int count, input bit with_hold);
        int burst;
        set_ellipse(pick_radius(), pick_radius(), 16'($urandom), pick_center(), pick_center());
        @(posedge clk);
        while (count > 0)
        begin
            burst = $urandom_range(1, 30);
            while (burst > 0 && count > 0)
            begin
                if (with_hold && count == 30)
                begin
                    hold_req = 1'b1;
                end
                send_angle(pick_angle(), $urandom_range(0, 1));
                burst--;
                count--;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.ray_angle = '0;
        in_ch.apply_tilt = 1'b0;
        hold_req = 1'b0;
        setups = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Both radii zero: the centre comes back.
        set_ellipse(24'd0, 24'd0, 16'h1234, 32'd5000, -32'd700);
        send_angle(16'h0000, 1'b0);
        send_angle(16'h4000, 1'b1);
        drain();
        // One radius zero: rays along the missing axis collapse to the centre.
        set_ellipse(24'd12800, 24'd0, 16'h2000, 32'd1000, -32'd1000);
        send_angle(16'h0000, 1'b0);
        send_angle(16'h4000, 1'b0);
        send_angle(16'h8000, 1'b1);
        send_angle(16'hC000, 1'b1);
        drain();
        set_ellipse(24'd0, 24'd7680, 16'hE000, 32'd0, 32'd0);
        send_angle(16'h0000, 1'b1);
        send_angle(16'h4000, 1'b0);
        send_angle(16'h8000, 1'b0);
        send_angle(16'h2000, 1'b1);
        drain();
        // Largest radii and centres at the range limits: coordinates saturate.
        set_ellipse(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_angle(16'h0000, 1'b0);
        send_angle(16'h2000, 1'b1);
        send_angle(16'hFFFF, 1'b1);
        send_angle(16'h0001, 1'b0);
        send_angle(16'hA000, 1'b0);
        drain();
        // A tiny major radius and a large ratio between the radii.
        set_ellipse(24'd1, 24'hFFFFFF, 16'h8000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_angle(16'h0001, 1'b1);
        send_angle(16'h5555, 1'b0);
        send_angle(16'hBFFF, 1'b1);
        send_angle(16'hAAAA, 1'b0);
        drain();

        for (int ph = 0; ph < 10; ph++)
        begin
            random_phase(53, ph == 3);
        end
        set_ellipse(24'd0, 24'd0, 16'd0, 32'd0, 32'd0);

        $display("Checked %0d points over %0d ellipse setups (%0d at centre, %0d clipped).",
                 points_checked, setups, center_seen, clip_seen);
        if (fail_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
